### rtl/tcbw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcbw_pkg: shared types and constants of the text cell buffer writer
// Store geometry, register indexes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package tcbw_pkg;

  localparam int MaxCols    = 128;
  localparam int MaxRows    = 64;
  localparam int StoreDepth = MaxCols * MaxRows;
  localparam int AddrW      = $clog2(StoreDepth);
  localparam int ColW       = $clog2(MaxCols);      // column index
  localparam int RowW       = $clog2(MaxRows);      // row index
  localparam int SizeCW     = $clog2(MaxCols + 1);  // effective width
  localparam int SizeRW     = $clog2(MaxRows + 1);  // effective height
  localparam int CoordW     = 16;
  localparam int CharW      = 8;
  localparam int ColourW    = 16;
  localparam int CellW      = CharW + ColourW;
  localparam int GridWW     = 8;
  localparam int GridHW     = 7;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 8;
  localparam int DivSteps   = CoordW;
  localparam int CntW       = $clog2(DivSteps);

  typedef enum logic [CfgIdxW-1:0] {
    CfgGridWidth   = 2'd0,
    CfgGridHeight  = 2'd1,
    CfgClipMode    = 2'd2,
    CfgOverlapMode = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    FuncWrite = 1'b0,
    FuncRead  = 1'b1
  } func_e;

  // controller -> datapath
  typedef struct packed {
    logic clr_step;     // clear one store entry
    logic capture;      // latch a new request
    logic load_direct;  // coordinates already in range
    logic mod_step;     // one restoring-division step on both coordinates
    logic addr_load;    // form the store address
    logic mem_read;     // read the addressed cell
    logic finish_acc;   // complete an accepted request
    logic finish_rej;   // complete a rejected request
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic out_of_range;
    logic wrap_en;
    logic mod_last;
  } dp_status_t;

endpackage

### rtl/tcbw_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcbw_ctrl: request sequencer
// One-hot state machine stepping the datapath through clear, resolve and access.
// ----------------------------------------------------------------------------
module tcbw_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  input  tcbw_pkg::dp_status_t  sts_i,
  output tcbw_pkg::ctrl_cmd_t   cmd_o,
  output logic                  busy
);

  typedef enum logic [6:0] {
    StClear = 7'b0000001,
    StIdle  = 7'b0000010,
    StCheck = 7'b0000100,
    StMod   = 7'b0001000,
    StAddr  = 7'b0010000,
    StRead  = 7'b0100000,
    StEval  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StClear: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = StIdle;
      end
      StIdle: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d       = StCheck;
        end
      end
      StCheck: begin
        priority if (sts_i.out_of_range && !sts_i.wrap_en) begin
          cmd_o.finish_rej = 1'b1;
          state_d          = StIdle;
        end else if (sts_i.out_of_range) begin
          state_d = StMod;
        end else begin
          cmd_o.load_direct = 1'b1;
          state_d           = StAddr;
        end
      end
      StMod: begin
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_last) state_d = StAddr;
      end
      StAddr: begin
        cmd_o.addr_load = 1'b1;
        state_d         = StRead;
      end
      StRead: begin
        cmd_o.mem_read = 1'b1;
        state_d        = StEval;
      end
      StEval: begin
        cmd_o.finish_acc = 1'b1;
        state_d          = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign busy = (state_q != StIdle);

endmodule

### rtl/tcbw_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcbw_datapath: registers, coordinate reduction and cell store
// Holds configuration, runs the restoring modulo, owns the cell memory.
// ----------------------------------------------------------------------------
module tcbw_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  tcbw_pkg::ctrl_cmd_t              cmd_i,
  output tcbw_pkg::dp_status_t             sts_o,
  input  logic                             cfg_valid_i,
  input  logic [tcbw_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [tcbw_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                             func_i,
  input  logic [tcbw_pkg::CoordW-1:0]      col_i,
  input  logic [tcbw_pkg::CoordW-1:0]      row_i,
  input  logic [tcbw_pkg::CharW-1:0]       char_code_i,
  input  logic [tcbw_pkg::ColourW-1:0]     colour_word_i,
  output logic                             done_o,
  output logic                             ok_o,
  output logic [tcbw_pkg::CharW-1:0]       read_char_o,
  output logic [tcbw_pkg::ColourW-1:0]     read_colour_o
);

  localparam int ProdW = tcbw_pkg::SizeCW + tcbw_pkg::RowW;

  // configuration
  logic [tcbw_pkg::GridWW-1:0] grid_w_q;
  logic [tcbw_pkg::GridHW-1:0] grid_h_q;
  logic                        clip_q;
  logic                        overlap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_w_q  <= tcbw_pkg::GridWW'(tcbw_pkg::MaxCols);
      grid_h_q  <= tcbw_pkg::GridHW'(tcbw_pkg::MaxRows);
      clip_q    <= 1'b0;
      overlap_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (tcbw_pkg::cfg_reg_e'(cfg_index_i))
        tcbw_pkg::CfgGridWidth:   grid_w_q  <= cfg_data_i[tcbw_pkg::GridWW-1:0];
        tcbw_pkg::CfgGridHeight:  grid_h_q  <= cfg_data_i[tcbw_pkg::GridHW-1:0];
        tcbw_pkg::CfgClipMode:    clip_q    <= cfg_data_i[0];
        tcbw_pkg::CfgOverlapMode: overlap_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // effective grid size: zero acts as one, oversize clamps to the store
  logic [tcbw_pkg::SizeCW-1:0] w_eff;
  logic [tcbw_pkg::SizeRW-1:0] h_eff;

  always_comb begin
    priority if (grid_w_q == '0) begin
      w_eff = tcbw_pkg::SizeCW'(1);
    end else if (32'(grid_w_q) > tcbw_pkg::MaxCols) begin
      w_eff = tcbw_pkg::SizeCW'(tcbw_pkg::MaxCols);
    end else begin
      w_eff = tcbw_pkg::SizeCW'(grid_w_q);
    end
    priority if (grid_h_q == '0) begin
      h_eff = tcbw_pkg::SizeRW'(1);
    end else if (32'(grid_h_q) > tcbw_pkg::MaxRows) begin
      h_eff = tcbw_pkg::SizeRW'(tcbw_pkg::MaxRows);
    end else begin
      h_eff = tcbw_pkg::SizeRW'(grid_h_q);
    end
  end

  // request capture and restoring modulo
  logic                          func_q;
  logic [tcbw_pkg::CharW-1:0]    char_q;
  logic [tcbw_pkg::ColourW-1:0]  colour_q;
  logic [tcbw_pkg::CoordW-1:0]   dq_c_q, dq_r_q;
  logic [tcbw_pkg::ColW-1:0]     rem_c_q, rem_c_d;
  logic [tcbw_pkg::RowW-1:0]     rem_r_q, rem_r_d;
  logic [tcbw_pkg::CntW-1:0]     cnt_q;
  logic [tcbw_pkg::ColW:0]       trial_c;
  logic [tcbw_pkg::RowW:0]       trial_r;

  assign trial_c = {rem_c_q, dq_c_q[tcbw_pkg::CoordW-1]};
  assign trial_r = {rem_r_q, dq_r_q[tcbw_pkg::CoordW-1]};

  always_comb begin
    if (32'(trial_c) >= 32'(w_eff)) begin
      rem_c_d = tcbw_pkg::ColW'(32'(trial_c) - 32'(w_eff));
    end else begin
      rem_c_d = tcbw_pkg::ColW'(trial_c);
    end
    if (32'(trial_r) >= 32'(h_eff)) begin
      rem_r_d = tcbw_pkg::RowW'(32'(trial_r) - 32'(h_eff));
    end else begin
      rem_r_d = tcbw_pkg::RowW'(trial_r);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.capture) begin
      cnt_q <= '0;
    end else if (cmd_i.mod_step) begin
      cnt_q <= cnt_q + tcbw_pkg::CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q   <= func_i;
      char_q   <= char_code_i;
      colour_q <= colour_word_i;
      dq_c_q   <= col_i;
      dq_r_q   <= row_i;
      rem_c_q  <= '0;
      rem_r_q  <= '0;
    end else if (cmd_i.load_direct) begin
      rem_c_q <= dq_c_q[tcbw_pkg::ColW-1:0];
      rem_r_q <= dq_r_q[tcbw_pkg::RowW-1:0];
    end else if (cmd_i.mod_step) begin
      rem_c_q <= rem_c_d;
      rem_r_q <= rem_r_d;
      dq_c_q  <= {dq_c_q[tcbw_pkg::CoordW-2:0], 1'b0};
      dq_r_q  <= {dq_r_q[tcbw_pkg::CoordW-2:0], 1'b0};
    end
  end

  // cell address: width * row + col
  logic [ProdW-1:0]           prod;
  logic [tcbw_pkg::AddrW-1:0] addr_q;

  assign prod = ProdW'(w_eff) * ProdW'(rem_r_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.addr_load) begin
      addr_q <= tcbw_pkg::AddrW'(prod + ProdW'(rem_c_q));
    end
  end

  // clearing pass after reset
  logic [tcbw_pkg::AddrW-1:0] clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_q <= clr_q + tcbw_pkg::AddrW'(1);
    end
  end

  // cell store
  logic [tcbw_pkg::CellW-1:0] mem_q [tcbw_pkg::StoreDepth];
  logic [tcbw_pkg::CellW-1:0] rdata_q;
  logic [tcbw_pkg::CellW-1:0] new_cell;
  logic [tcbw_pkg::CellW-1:0] wdata;
  logic [tcbw_pkg::AddrW-1:0] waddr;
  logic                       wen;
  logic                       occupied;

  assign occupied = (rdata_q[tcbw_pkg::CellW-1 -: tcbw_pkg::CharW] != '0);
  assign new_cell = (occupied && overlap_q) ? '0 : {char_q, colour_q};
  assign wen      = cmd_i.clr_step ||
                    (cmd_i.finish_acc && (func_q == tcbw_pkg::FuncWrite));
  assign waddr    = cmd_i.clr_step ? clr_q : addr_q;
  assign wdata    = cmd_i.clr_step ? '0 : new_cell;

  always_ff @(posedge clk_i) begin
    if (wen) begin
      mem_q[waddr] <= wdata;
    end
    if (cmd_i.mem_read) begin
      rdata_q <= mem_q[addr_q];
    end
  end

  // result registers
  logic                         done_q;
  logic                         ok_q;
  logic [tcbw_pkg::CharW-1:0]   rchar_q;
  logic [tcbw_pkg::ColourW-1:0] rcolour_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.finish_acc || cmd_i.finish_rej;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish_rej) begin
      ok_q      <= 1'b0;
      rchar_q   <= '0;
      rcolour_q <= '0;
    end else if (cmd_i.finish_acc) begin
      ok_q <= 1'b1;
      if (func_q == tcbw_pkg::FuncRead) begin
        rchar_q   <= rdata_q[tcbw_pkg::CellW-1 -: tcbw_pkg::CharW];
        rcolour_q <= rdata_q[tcbw_pkg::ColourW-1:0];
      end else begin
        rchar_q   <= '0;
        rcolour_q <= '0;
      end
    end
  end

  assign done_o        = done_q;
  assign ok_o          = ok_q;
  assign read_char_o   = rchar_q;
  assign read_colour_o = rcolour_q;

  assign sts_o.clr_last     = (clr_q == tcbw_pkg::AddrW'(tcbw_pkg::StoreDepth - 1));
  assign sts_o.out_of_range = (32'(dq_c_q) >= 32'(w_eff)) || (32'(dq_r_q) >= 32'(h_eff));
  assign sts_o.wrap_en      = clip_q;
  assign sts_o.mod_last     = (cnt_q == tcbw_pkg::CntW'(tcbw_pkg::DivSteps - 1));

endmodule

### rtl/text_cell_buffer_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_cell_buffer_writer: character cell store with (col, row) access
// Write or read one 24-bit cell per request, with clip/wrap and overlap modes.
// ----------------------------------------------------------------------------
// Usage:
//   Issue a request by raising start while busy is low; func_i, col_i, row_i,
//   char_code_i and colour_word_i are sampled on that edge. One result comes
//   back on ok_o / read_char_o / read_colour_o, valid for exactly the one
//   cycle that done_o is high. The receiver cannot stall; take it or drop it.
//   Sequence: a rejected request (out of range, clip mode) ends at the range
//   check; one in range goes on to address, store read and read-modify-write.
//   When coordinates wrap, the 16-step restoring modulo that reduces both
//   coordinates in parallel runs before the address step. A new request can
//   be accepted at the edge that takes the result.
//   Configuration writes (cfg_valid_i, always ready) set grid width, grid
//   height, clip mode and overlap mode; write them only while idle.
//   Reset: the store is zeroed by a clearing pass, one cell per cycle; busy
//   stays high until it ends. Configuration is taken as ever.
// ----------------------------------------------------------------------------
module text_cell_buffer_writer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // request channel
  input  logic                              start,
  output logic                              busy,
  input  logic                              func_i,
  input  logic [tcbw_pkg::CoordW-1:0]       col_i,
  input  logic [tcbw_pkg::CoordW-1:0]       row_i,
  input  logic [tcbw_pkg::CharW-1:0]        char_code_i,
  input  logic [tcbw_pkg::ColourW-1:0]      colour_word_i,
  // result strobe
  output logic                              done_o,
  output logic                              ok_o,
  output logic [tcbw_pkg::CharW-1:0]        read_char_o,
  output logic [tcbw_pkg::ColourW-1:0]      read_colour_o,
  // configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tcbw_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [tcbw_pkg::CfgDataW-1:0]     cfg_data_i
);

  tcbw_pkg::ctrl_cmd_t  cmd;
  tcbw_pkg::dp_status_t sts;
  logic                 cfg_we;

  // Registers accept a write every cycle.
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // Sequence each request: clear after reset, range check, wrap, access.
  tcbw_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  // Hold configuration, coordinates, the cell store and the result.
  tcbw_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_valid_i   (cfg_we),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .func_i        (func_i),
    .col_i         (col_i),
    .row_i         (row_i),
    .char_code_i   (char_code_i),
    .colour_word_i (colour_word_i),
    .done_o        (done_o),
    .ok_o          (ok_o),
    .read_char_o   (read_char_o),
    .read_colour_o (read_colour_o)
  );

endmodule

### rtl/tcbw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcbw_checker: port-level checks of the text cell buffer writer
// Attached to the top level by the bind below.
// ----------------------------------------------------------------------------
module tcbw_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             start,
  input logic                             busy,
  input logic                             done_o,
  input logic                             ok_o,
  input logic [tcbw_pkg::CharW-1:0]       read_char_o,
  input logic [tcbw_pkg::ColourW-1:0]     read_colour_o
);

  // an accepted request keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // result strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("done strobe longer than one cycle");

  // a result always follows a busy cycle
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result without a request in progress");

  // rejected requests return no data
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !ok_o) |-> (read_char_o == '0 && read_colour_o == '0))
    else $error("rejected request returned data");

endmodule

bind text_cell_buffer_writer tcbw_checker u_tcbw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .done_o        (done_o),
  .ok_o          (ok_o),
  .read_char_o   (read_char_o),
  .read_colour_o (read_colour_o)
);

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the text cell buffer writer
// Drives cell write and read requests under several grid sizes, clip and
// overlap modes, mirrors the cell store in a local predictor, and checks
// every strobed result against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module testbench;

  import tcbw_pkg::*;

  localparam int RandPhases    = 6;
  localparam int PhaseRequests = 217;
  localparam int MaxReports    = 30;

  typedef struct {
    func_e                func;
    logic [CoordW-1:0]    col;
    logic [CoordW-1:0]    row;
    logic [CharW-1:0]     char_code;
    logic [ColourW-1:0]   colour;
  } cell_request_t;

  typedef struct {
    logic                 ok;
    logic [CharW-1:0]     rd_char;
    logic [ColourW-1:0]   rd_colour;
  } cell_result_t;

  // Clock and reset. Every DUT input starts at a known value.
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                 start         = 1'b0;
  logic                 busy;
  logic                 func_i        = 1'b0;
  logic [CoordW-1:0]    col_i         = '0;
  logic [CoordW-1:0]    row_i         = '0;
  logic [CharW-1:0]     char_code_i   = '0;
  logic [ColourW-1:0]   colour_word_i = '0;
  logic                 done_o;
  logic                 ok_o;
  logic [CharW-1:0]     read_char_o;
  logic [ColourW-1:0]   read_colour_o;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i   = '0;
  logic [CfgDataW-1:0]  cfg_data_i    = '0;

  always #4 clk_i = ~clk_i;

  text_cell_buffer_writer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .func_i        (func_i),
    .col_i         (col_i),
    .row_i         (row_i),
    .char_code_i   (char_code_i),
    .colour_word_i (colour_word_i),
    .done_o        (done_o),
    .ok_o          (ok_o),
    .read_char_o   (read_char_o),
    .read_colour_o (read_colour_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // --------------------------------------------------------------------------
  // Predictor state: a mirror of the cell store and of the four registers.
  // --------------------------------------------------------------------------
  logic [CharW-1:0]   cell_char_q   [StoreDepth];
  logic [ColourW-1:0] cell_colour_q [StoreDepth];
  logic [GridWW-1:0]  grid_width_q  = 8'd128;
  logic [GridHW-1:0]  grid_height_q = 7'd64;
  logic               wrap_en_q     = 1'b0;
  logic               clear_hit_q   = 1'b0;

  // Results predicted at acceptance, oldest first.
  cell_result_t pending_results_q[$];

  int unsigned mismatch_count = 0;
  int unsigned n_reads        = 0;
  int unsigned n_writes       = 0;
  int unsigned n_rejected     = 0;
  int unsigned n_wrapped      = 0;
  int unsigned n_cleared      = 0;
  int unsigned n_settings     = 0;
  logic        burst_mode     = 1'b0;

  // A size of zero acts as one, anything above the store bound as the bound.
  function automatic int unsigned effective_size(int unsigned raw, int unsigned bound);
    if (raw == 0) return 1;
    if (raw > bound) return bound;
    return raw;
  endfunction

  // Map (col, row) onto a store address; return 0 when the request is
  // rejected. In wrap mode both coordinates fold as soon as either is out.
  function automatic logic locate_cell(input logic [CoordW-1:0] col,
                                       input logic [CoordW-1:0] row,
                                       output int unsigned addr);
    int unsigned w, h, c, r;
    w = effective_size(32'(grid_width_q), MaxCols);
    h = effective_size(32'(grid_height_q), MaxRows);
    c = 32'(col);
    r = 32'(row);
    addr = 0;
    if (c >= w || r >= h) begin
      if (!wrap_en_q) return 1'b0;
      c = c % w;
      r = r % h;
      n_wrapped++;
    end
    addr = w * r + c;
    return 1'b1;
  endfunction

  // Apply one accepted request to the mirror and return its result.
  function automatic cell_result_t apply_cell_request(cell_request_t req);
    cell_result_t res;
    int unsigned  addr;
    res = '{ok: 1'b0, rd_char: '0, rd_colour: '0};
    if (!locate_cell(req.col, req.row, addr)) begin
      n_rejected++;
      return res;
    end
    res.ok = 1'b1;
    if (req.func == FuncRead) begin
      n_reads++;
      res.rd_char   = cell_char_q[addr];
      res.rd_colour = cell_colour_q[addr];
      return res;
    end
    n_writes++;
    // Only the character decides occupancy; a bare colour counts as empty.
    if (cell_char_q[addr] != '0 && clear_hit_q) begin
      n_cleared++;
      cell_char_q[addr]   = '0;
      cell_colour_q[addr] = '0;
    end else begin
      cell_char_q[addr]   = req.char_code;
      cell_colour_q[addr] = req.colour;
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Result checker: every done_o strobe pairs with the oldest prediction.
  // Values are read right after the edge, so they are the ones the edge took.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    cell_result_t exp_res;
    if (rst_ni && done_o) begin
      if (pending_results_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports)
          $display("%0t: unexpected result, expected none, got ok=%0d char=%0h colour=%0h",
                   $time, ok_o, read_char_o, read_colour_o);
      end else begin
        exp_res = pending_results_q.pop_front();
        if (ok_o !== exp_res.ok) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports)
            $display("%0t: ok mismatch, expected %0d, got %0d", $time, exp_res.ok, ok_o);
        end
        if (read_char_o !== exp_res.rd_char) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports)
            $display("%0t: read_char mismatch, expected %0h, got %0h",
                     $time, exp_res.rd_char, read_char_o);
        end
        if (read_colour_o !== exp_res.rd_colour) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports)
            $display("%0t: read_colour mismatch, expected %0h, got %0h",
                     $time, exp_res.rd_colour, read_colour_o);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request driver. Present the request, hold it until an edge sees busy low,
  // then predict. Leave start high when the next request follows at once;
  // otherwise drop it at the acceptance edge so nothing is taken twice.
  // --------------------------------------------------------------------------
  task automatic send_cell_request(cell_request_t req);
    int unsigned gap;
    start         <= 1'b1;
    func_i        <= req.func;
    col_i         <= req.col;
    row_i         <= req.row;
    char_code_i   <= req.char_code;
    colour_word_i <= req.colour;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_results_q.push_back(apply_cell_request(req));
    // Toggle now and then between back-to-back bursts and random gaps.
    if ($urandom_range(0, 31) == 0) burst_mode = ~burst_mode;
    gap = burst_mode ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop start and wait until every predicted result has come back.
  task automatic settle_block();
    start <= 1'b0;
    while (pending_results_q.size() != 0) @(posedge clk_i);
  endtask

  // Write one register through the config channel and mirror it. Valid
  // stays high so the next write can follow at once; the caller drops it.
  task automatic write_grid_reg(cfg_reg_e idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CfgGridWidth:   grid_width_q  = data[GridWW-1:0];
      CfgGridHeight:  grid_height_q = data[GridHW-1:0];
      CfgClipMode:    wrap_en_q     = data[0];
      CfgOverlapMode: clear_hit_q   = data[0];
      default: ;
    endcase
  endtask

  task automatic program_grid(logic [7:0] width, logic [7:0] height,
                              logic wrap, logic clear_hit);
    write_grid_reg(CfgGridWidth, width);
    write_grid_reg(CfgGridHeight, height);
    write_grid_reg(CfgClipMode, {7'd0, wrap});
    write_grid_reg(CfgOverlapMode, {7'd0, clear_hit});
    cfg_valid_i <= 1'b0;
    n_settings++;
  endtask

  function automatic cell_request_t make_request(func_e func, int unsigned col,
                                                 int unsigned row, int unsigned ch,
                                                 int unsigned colour);
    cell_request_t req;
    req.func      = func;
    req.col       = col[CoordW-1:0];
    req.row       = row[CoordW-1:0];
    req.char_code = ch[CharW-1:0];
    req.colour    = colour[ColourW-1:0];
    return req;
  endfunction

  // Skew coordinates toward the grid so reads land on written cells, with
  // the edges, far-out values and the extremes mixed in.
  function automatic int unsigned pick_coord(int unsigned span);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom_range(0, span - 1);
      5, 6:          return $urandom_range(span - 1, span + 2);
      7:             return $urandom_range(0, 65535);
      8:             return $urandom_range(0, 1) ? 65535 : 0;
      default:       return $urandom_range(0, 4 * span);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset settings: full grid, reject out-of-range, replace occupied cells.
  task automatic test_reset_grid();
    send_cell_request(make_request(FuncRead,  5, 5, 'h00, 'h0000));
    send_cell_request(make_request(FuncWrite, 0, 0, 'hFF, 'hFFFF));
    send_cell_request(make_request(FuncRead,  0, 0, 'h00, 'h0000));
    send_cell_request(make_request(FuncWrite, 127, 63, 'h01, 'h0000));
    send_cell_request(make_request(FuncRead,  127, 63, 'h00, 'h0000));
    send_cell_request(make_request(FuncWrite, 128, 0, 'h11, 'h2222));
    send_cell_request(make_request(FuncWrite, 0, 64, 'h33, 'h4444));
    send_cell_request(make_request(FuncRead,  'hFFFF, 'hFFFF, 'hFF, 'hFFFF));
    // Occupied cell, replace mode: new contents win.
    send_cell_request(make_request(FuncWrite, 0, 0, 'h80, 'h1234));
    send_cell_request(make_request(FuncRead,  0, 0, 'h00, 'h0000));
    // Character zero with a colour: the cell still counts as empty.
    send_cell_request(make_request(FuncWrite, 3, 3, 'h00, 'hBEEF));
    settle_block();
  endtask

  // Clear-on-overlap mode: occupied cells get wiped, empty ones written.
  task automatic test_overlap_clear();
    program_grid(8'd128, 8'd64, 1'b0, 1'b1);
    send_cell_request(make_request(FuncWrite, 3, 3, 'h55, 'h00FF));
    send_cell_request(make_request(FuncRead,  3, 3, 'h00, 'h0000));
    send_cell_request(make_request(FuncWrite, 3, 3, 'hAA, 'h5A5A));
    send_cell_request(make_request(FuncRead,  3, 3, 'h00, 'h0000));
    send_cell_request(make_request(FuncWrite, 0, 0, 'h7E, 'h0F0F));
    send_cell_request(make_request(FuncRead,  0, 0, 'h00, 'h0000));
    settle_block();
  endtask

  // Wrap mode with zero, oversized and odd grid sizes.
  task automatic test_wrap_sizes();
    // Zero width and height act as a single cell.
    program_grid(8'd0, 8'd0, 1'b1, 1'b1);
    send_cell_request(make_request(FuncWrite, 'hFFFF, 'hFFFF, 'h42, 'h0F0F));
    send_cell_request(make_request(FuncRead,  7, 0, 'h00, 'h0000));
    settle_block();
    // Oversized width clamps to the store; height drops its top data bit.
    program_grid(8'd255, 8'hFF, 1'b1, 1'b0);
    send_cell_request(make_request(FuncWrite, 200, 100, 'hC3, 'hA55A));
    send_cell_request(make_request(FuncRead,  72, 36, 'h00, 'h0000));
    settle_block();
    // One coordinate out of range folds both.
    program_grid(8'd5, 8'd3, 1'b1, 1'b0);
    send_cell_request(make_request(FuncWrite, 7, 1, 'h3C, 'h8001));
    send_cell_request(make_request(FuncRead,  2, 4, 'h00, 'h0000));
    send_cell_request(make_request(FuncRead,  'hFFFF, 2, 'h00, 'h0000));
    settle_block();
  endtask

  // Random traffic over a series of grid settings, extremes first.
  task automatic test_random_traffic();
    int unsigned   phase_idx, n, span_c, span_r, ch, colour;
    cell_request_t req;
    for (phase_idx = 0; phase_idx < RandPhases; phase_idx++) begin
      case (phase_idx)
        0: program_grid(8'd128, 8'd64, 1'b0, 1'b0);
        1: program_grid(8'd1, 8'd1, 1'b1, 1'b1);
        2: program_grid(8'd0, 8'd0, 1'b0, 1'b1);
        3: program_grid(8'd255, 8'hFF, 1'b1, 1'b0);
        4: program_grid(8'($urandom_range(1, 128)), 8'($urandom_range(1, 64)),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        default: program_grid(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      endcase
      span_c = effective_size(32'(grid_width_q), MaxCols);
      span_r = effective_size(32'(grid_height_q), MaxRows);
      for (n = 0; n < PhaseRequests; n++) begin
        ch     = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 255);
        colour = $urandom_range(0, 65535);
        req = make_request(($urandom_range(0, 4) < 2) ? FuncRead : FuncWrite,
                           pick_coord(span_c), pick_coord(span_r), ch, colour);
        send_cell_request(req);
      end
      settle_block();
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    foreach (cell_char_q[i]) begin
      cell_char_q[i]   = '0;
      cell_colour_q[i] = '0;
    end
    // Hold reset from time zero, then release it on a clock edge; the block then
    // clears its store on its own and keeps busy high until done, which the driver waits out.
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_grid();
    test_overlap_clear();
    test_wrap_sizes();
    test_random_traffic();

    // Let a late or stray strobe show up before judging.
    repeat (30) @(posedge clk_i);

    $display("Covered %0d requests over %0d grid settings: %0d writes (%0d cleared),",
             n_reads + n_writes + n_rejected, n_settings, n_writes, n_cleared);
    $display("%0d reads, %0d rejected, %0d wrapped; %0d mismatches.",
             n_reads, n_rejected, n_wrapped, mismatch_count);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, clearing pass included.
  initial begin
    #4_000_000;
    $display("Timeout with %0d results outstanding", pending_results_q.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
